// ===== design/cdsd_pkg.sv =====
// constants, segment table and hour rewrite for the clock digit scan driver
`default_nettype none
package cdsd_pkg;

	localparam int unsigned BLINK_PERIOD    = 500;
	localparam int unsigned BLINK_OFF_TICKS = 250;
	localparam int unsigned BLINK_W         = 9;

	typedef logic [2:0] pos_t;
	typedef logic [1:0] cfg_idx_t;
	typedef logic [7:0] seg_t;

	localparam pos_t POS_H10   = 3'd0;
	localparam pos_t POS_H01   = 3'd1;
	localparam pos_t POS_COLON = 3'd2;
	localparam pos_t POS_M10   = 3'd3;
	localparam pos_t POS_M01   = 3'd4;

	localparam cfg_idx_t CFG_HOUR_24     = 2'd0;
	localparam cfg_idx_t CFG_BLINK_WHOLE = 2'd1;
	localparam cfg_idx_t CFG_BLINK_COLON = 2'd2;

	localparam logic [3:0] ROW_COLON = 4'd10;

	localparam seg_t SEG_PM_DOT    = 8'h80;
	localparam seg_t SEG_ALARM_DOT = 8'h04;
	localparam seg_t SEG_BLANK     = 8'hFF;

	localparam logic [7:0] HOURS_NOON = 8'h12;
	localparam logic [7:0] HOURS_BAD  = 8'h88;

	function automatic seg_t seg_pattern(input logic [3:0] row);
		seg_t pat;
		case (row)
			4'd0:    pat = 8'hC0;
			4'd1:    pat = 8'hF9;
			4'd2:    pat = 8'hA4;
			4'd3:    pat = 8'hB0;
			4'd4:    pat = 8'h99;
			4'd5:    pat = 8'h92;
			4'd6:    pat = 8'h82;
			4'd7:    pat = 8'hF8;
			4'd8:    pat = 8'h80;
			4'd9:    pat = 8'h98;
			4'd10:   pat = 8'hFC;
			4'd11:   pat = 8'h80;
			4'd12:   pat = 8'h04;
			default: pat = SEG_BLANK;
		endcase
		return pat;
	endfunction

	function automatic logic [7:0] hours_24(input logic [7:0] hours, input logic pm);
		logic [7:0] res;
		if (!pm) begin
			res = (hours == HOURS_NOON) ? 8'h00 : hours;
		end else begin
			case (hours) inside
				HOURS_NOON:     res = HOURS_NOON;
				[8'h01:8'h07]:  res = hours + 8'h12;
				8'h08:          res = 8'h20;
				8'h09:          res = 8'h21;
				8'h10:          res = 8'h22;
				8'h11:          res = 8'h23;
				default:        res = HOURS_BAD;
			endcase
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== design/clock_digit_scan_driver.sv =====
// scan driver for a five-position multiplexed seven-segment clock display
// the result is registered and appears in the cycle after its input item is accepted
// throughput: one item per cycle; a new item is taken while the result
// register is empty or being drained in the same cycle
// reset: digit position set to M01, blink counter and configuration registers cleared,
// no result held
`default_nettype none
module clock_digit_scan_driver import cdsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire cfg_idx_t    cfg_index,
	input  wire logic        cfg_data,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [23:0] s_tdata,   // hours_bcd[7:0], minutes_bcd[7:0], is_pm, alarm_armed
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [15:0] m_tdata    // digit_select[2:0], segment_pins[7:0]
);

	logic hour_24_q, blink_whole_q, blink_colon_q;
	pos_t pos_q;
	logic [BLINK_W-1:0] blink_q;
	logic out_valid_q;
	pos_t out_pos_q;
	seg_t out_seg_q;

	logic [7:0] hours_in, minutes_in, hours;
	logic pm, alarm, accept, off_phase;
	pos_t pos_next;
	logic [BLINK_W-1:0] blink_next;
	logic [3:0] row;
	seg_t pins;

	assign hours_in   = s_tdata[7:0];
	assign minutes_in = s_tdata[15:8];
	assign pm         = s_tdata[16];
	assign alarm      = s_tdata[17];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		pos_next   = (pos_q >= POS_M01) ? POS_H10 : pos_q + 3'd1;
		blink_next = (blink_q == BLINK_W'(BLINK_PERIOD - 1)) ? '0 : blink_q + 1'b1;
		off_phase  = blink_next < BLINK_W'(BLINK_OFF_TICKS);
		hours      = hour_24_q ? hours_24(hours_in, pm) : hours_in;
		case (pos_next)
			POS_H10:   row = hours[7:4];
			POS_H01:   row = hours[3:0];
			POS_COLON: row = ROW_COLON;
			POS_M10:   row = minutes_in[7:4];
			default:   row = minutes_in[3:0];
		endcase
		pins = seg_pattern(row);
		if (pos_next == POS_H10 && row == 4'd0)
			pins = SEG_BLANK;
		if (pos_next == POS_M01 && !hour_24_q && pm)
			pins = pins & ~SEG_PM_DOT;
		if (pos_next == POS_COLON && alarm)
			pins = pins & ~SEG_ALARM_DOT;
		if (blink_whole_q && off_phase) begin
			pins = SEG_BLANK;
		end else if (pos_next == POS_COLON && off_phase && blink_colon_q) begin
			pins = alarm ? (SEG_BLANK & ~SEG_ALARM_DOT) : SEG_BLANK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_24_q     <= 1'b0;
			blink_whole_q <= 1'b0;
			blink_colon_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HOUR_24:     hour_24_q     <= cfg_data;
				CFG_BLINK_WHOLE: blink_whole_q <= cfg_data;
				CFG_BLINK_COLON: blink_colon_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_M01;
			blink_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q       <= pos_next;
				blink_q     <= blink_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_pos_q <= pos_next;
			out_seg_q <= pins;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_seg_q, out_pos_q};

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n) pos_q <= POS_M01)
		else $error("digit position out of range");
	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q < BLINK_W'(BLINK_PERIOD))
		else $error("blink counter out of range");
	a_out_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_tvalid && m_tdata[2:0] == pos_q))
		else $error("result position differs from scan state");
	a_blank_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && blink_whole_q && off_phase) |=> (m_tdata[10:3] == SEG_BLANK))
		else $error("display not blanked in blink-off phase");

endmodule
`default_nettype wire
